[rtl/core/iee_pkg.sv]
// ---------------------------------------------------------------------------
// iee_pkg
// Shared types and constants for the infix expression evaluator core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iee_pkg;

   // Deepest parenthesis nesting the frame stack holds.
   localparam int MAX_NEST = 16;
   localparam int DEPTH_W  = $clog2(MAX_NEST + 1);
   localparam int ADDR_W   = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

   localparam logic [7:0] CH_END   = 8'h00;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_TIMES = 8'h2A;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_TOKEN = 2'd1;
   localparam logic [1:0] ST_BAD_END   = 2'd2;
   localparam logic [1:0] ST_TOO_DEEP  = 2'd3;

   typedef enum logic {
      PH_OPERAND,
      PH_OPERATOR
   } phase_type;

   typedef enum logic [2:0] {
      TK_END,
      TK_DIGIT,
      TK_OPEN,
      TK_CLOSE,
      TK_PLUS,
      TK_TIMES,
      TK_OTHER
   } token_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_DIGIT,
      OP_OPEN,
      OP_PLUS,
      OP_CLOSE,
      OP_END
   } stack_op_type;

   typedef struct packed {
      stack_op_type        op;
      logic [3:0]          digit;
      logic [DEPTH_W-1:0]  depth;
      logic [DEPTH_W-1:0]  next_depth;
   } stack_cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] bad_char;
   } end_info_type;

   typedef struct packed {
      logic [31:0] sum;
      logic [31:0] prod;
   } frame_type;

endpackage

`default_nettype wire

[rtl/core/iee_ctrl.sv]
// ---------------------------------------------------------------------------
// iee_ctrl
// Token decoder and parser state: phase, nesting depth and latched error.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iee_ctrl
   import iee_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire logic [7:0]    ch,
   output stack_cmd_type      cmd,
   output end_info_type       end_info
);

   localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_NEST);

   phase_type          phase_ff, phase_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [1:0]         err_code_ff, err_code_in;
   logic [7:0]         err_char_ff, err_char_in;
   token_type          tok;
   logic [7:0]         digit_full;

   always_comb begin
      if (ch == CH_END) begin
         tok = TK_END;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
         tok = TK_DIGIT;
      end else begin
         case (ch)
            CH_OPEN:  tok = TK_OPEN;
            CH_CLOSE: tok = TK_CLOSE;
            CH_PLUS:  tok = TK_PLUS;
            CH_TIMES: tok = TK_TIMES;
            default:  tok = TK_OTHER;
         endcase
      end
   end

   // Next state.
   always_comb begin
      phase_in    = phase_ff;
      depth_in    = depth_ff;
      err_code_in = err_code_ff;
      err_char_in = err_char_ff;
      if (fire) begin
         if (tok == TK_END) begin
            phase_in    = PH_OPERAND;
            depth_in    = '0;
            err_code_in = ST_OK;
            err_char_in = '0;
         end else if (err_code_ff == ST_OK) begin
            unique case (phase_ff)
               PH_OPERAND: begin
                  if (tok == TK_DIGIT) begin
                     phase_in = PH_OPERATOR;
                  end else if (tok == TK_OPEN) begin
                     if (depth_ff >= MAX_DEPTH) begin
                        err_code_in = ST_TOO_DEEP;
                        err_char_in = '0;
                     end else begin
                        depth_in = depth_ff + 1'b1;
                     end
                  end else begin
                     err_code_in = ST_BAD_TOKEN;
                     err_char_in = ch;
                  end
               end
               PH_OPERATOR: begin
                  if (tok == TK_PLUS || tok == TK_TIMES) begin
                     phase_in = PH_OPERAND;
                  end else if (tok == TK_CLOSE && depth_ff != '0) begin
                     depth_in = depth_ff - 1'b1;
                  end else begin
                     err_code_in = ST_BAD_TOKEN;
                     err_char_in = ch;
                  end
               end
               default: phase_in = PH_OPERAND;
            endcase
         end
      end
   end

   // Outputs: the stack command and the end-of-expression status.
   always_comb begin
      digit_full          = ch - CH_ZERO;
      cmd.op              = OP_NONE;
      cmd.digit           = digit_full[3:0];
      cmd.depth           = depth_ff;
      cmd.next_depth      = depth_in;
      if (fire) begin
         if (tok == TK_END) begin
            cmd.op = OP_END;
         end else if (err_code_ff == ST_OK) begin
            unique case (phase_ff)
               PH_OPERAND: begin
                  if (tok == TK_DIGIT) begin
                     cmd.op = OP_DIGIT;
                  end else if (tok == TK_OPEN && depth_ff < MAX_DEPTH) begin
                     cmd.op = OP_OPEN;
                  end
               end
               PH_OPERATOR: begin
                  if (tok == TK_PLUS) begin
                     cmd.op = OP_PLUS;
                  end else if (tok == TK_CLOSE && depth_ff != '0) begin
                     cmd.op = OP_CLOSE;
                  end
               end
               default: cmd.op = OP_NONE;
            endcase
         end
      end

      if (err_code_ff != ST_OK) begin
         end_info.status   = err_code_ff;
         end_info.bad_char = (err_code_ff == ST_BAD_TOKEN) ? err_char_ff : 8'h00;
      end else if (phase_ff == PH_OPERAND || depth_ff != '0) begin
         end_info.status   = ST_BAD_END;
         end_info.bad_char = 8'h00;
      end else begin
         end_info.status   = ST_OK;
         end_info.bad_char = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OPERAND;
         depth_ff    <= '0;
         err_code_ff <= ST_OK;
         err_char_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         depth_ff    <= depth_in;
         err_code_ff <= err_code_in;
         err_char_ff <= err_char_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/iee_frame_stack.sv]
// ---------------------------------------------------------------------------
// iee_frame_stack
// Current sum/product frame in registers; enclosing frames in a memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iee_frame_stack
   import iee_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  stack_cmd_type      cmd,
   output logic [31:0]        end_sum
);

   frame_type          mem [MAX_NEST];
   logic [31:0]        sum_ff, sum_in;
   logic [31:0]        prod_ff, prod_in;
   frame_type          rd_ff;
   frame_type          byp_ff;
   logic               byp_valid_ff, byp_valid_in;
   frame_type          below;
   logic [31:0]        inner;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [DEPTH_W-1:0] rd_level;

   // The memory is read at the level just below the frame that will be current
   // next cycle (entry 0 at the top level), so a close finds its parent frame ready.
   always_comb begin
      rd_level = cmd.next_depth - 1'b1;
      rd_addr  = (cmd.next_depth == '0) ? '0 : ADDR_W'(rd_level);
      wr_addr  = ADDR_W'(cmd.depth);
   end

   // A push writes the same entry the read port samples at that edge, so
   // the pushed frame is forwarded for one cycle.
   always_comb begin
      below        = byp_valid_ff ? byp_ff : rd_ff;
      inner        = sum_ff + prod_ff;
      end_sum      = inner;
      byp_valid_in = (cmd.op == OP_OPEN);
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      case (cmd.op)
         OP_DIGIT: prod_in = prod_ff * {28'd0, cmd.digit};
         OP_PLUS: begin
            sum_in  = inner;
            prod_in = 32'd1;
         end
         OP_OPEN, OP_END: begin
            sum_in  = 32'd0;
            prod_in = 32'd1;
         end
         OP_CLOSE: begin
            sum_in  = below.sum;
            prod_in = below.prod * inner;
         end
         default: prod_in = prod_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OPEN) begin
         mem[wr_addr] <= '{sum: sum_ff, prod: prod_ff};
      end
      rd_ff  <= mem[rd_addr];
      byp_ff <= '{sum: sum_ff, prod: prod_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= 32'd0;
         prod_ff      <= 32'd1;
         byp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         prod_ff      <= prod_in;
         byp_valid_ff <= byp_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/infix_expression_evaluator_core.sv]
// ---------------------------------------------------------------------------
// infix_expression_evaluator_core
// Evaluates '+', '*', parentheses and single digits, one character a word.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  req_ch (8b, 0 ends an expression)
//  rsp      out        rsp_valid/rsp_stall  rsp_value, rsp_status, rsp_bad_char
//
//  One character is taken each cycle that req_stall is low; a result leaves
//  in the cycle after the end marker is taken. The frame stack is read one level
//  below the next current frame each cycle, so a ')' needs no wait.
//  Reset is synchronous and returns the parser to an empty expression.
//  req_stall is high only while a result is held and rsp_stall is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module infix_expression_evaluator_core
   import iee_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_ch,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_value,
   output logic [1:0]               rsp_status,
   output logic [7:0]               rsp_bad_char
);

   logic          fire;
   stack_cmd_type cmd;
   end_info_type  end_info;
   logic [31:0]   end_sum;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   value_ff;
   logic [1:0]    status_ff;
   logic [7:0]    bad_char_ff;
   logic          load;

   iee_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .ch       (req_ch),
      .cmd      (cmd),
      .end_info (end_info)
   );

   iee_frame_stack u_stack (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .end_sum (end_sum)
   );

   always_comb begin
      req_stall    = rsp_valid_ff && rsp_stall;
      fire         = req_valid && !req_stall;
      load         = fire && (req_ch == CH_END);
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff    <= (end_info.status == ST_OK) ? end_sum : 32'd0;
         status_ff   <= end_info.status;
         bad_char_ff <= end_info.bad_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = value_ff;
   assign rsp_status   = status_ff;
   assign rsp_bad_char = bad_char_ff;

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result held");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_ch == CH_END) |=> rsp_valid)
      else $error("end marker taken but no result word");

   a_bad_char_only_on_token: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_BAD_TOKEN) |-> (rsp_bad_char == 8'h00))
      else $error("bad_char set without unexpected token status");

   a_value_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_value == 32'sd0))
      else $error("nonzero value with error status");

endmodule

`default_nettype wire

[bench/expr_result_checker.sv]
// ---------------------------------------------------------------------------
// expr_result_checker
// Watches both channels of the infix expression evaluator core. Every
// accepted character word is run through a local model of the parser, and
// each end marker queues the result it should produce. Every accepted result
// is compared field by field with the oldest queued one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module expr_result_checker
   import iee_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [7:0]         req_ch,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic signed [31:0] rsp_value,
   input  wire logic [1:0]         rsp_status,
   input  wire logic [7:0]         rsp_bad_char,
   output int                      fail_count,
   output int                      pending
);

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
      logic [7:0]  bad_char;
   } expr_result_type;

   expr_result_type results_due[$];

   // Parser state: a top-level sum/product frame plus one per open parenthesis.
   phase_type   phase;
   int          nest;
   logic [31:0] frame_sum  [0:MAX_NEST];
   logic [31:0] frame_prod [0:MAX_NEST];
   logic [1:0]  err_code;
   logic [7:0]  err_char;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic clear_expr();
      phase = PH_OPERAND;
      nest = 0;
      frame_sum[0] = 32'd0;
      frame_prod[0] = 32'd1;
      err_code = ST_OK;
      err_char = 8'd0;
   endtask

   task automatic latch_error(input logic [1:0] code, input logic [7:0] ch);
      err_code = code;
      err_char = ch;
   endtask

   task automatic apply_char(input logic [7:0] ch);
      expr_result_type r;
      logic [31:0]     inner;
      if (ch == CH_END) begin
         r.value = 32'd0;
         r.status = err_code;
         r.bad_char = (err_code == ST_BAD_TOKEN) ? err_char : 8'd0;
         if (err_code == ST_OK) begin
            if (phase == PH_OPERAND || nest != 0) begin
               r.status = ST_BAD_END;
            end else begin
               r.value = frame_sum[0] + frame_prod[0];
            end
         end
         results_due.push_back(r);
         clear_expr();
      end else if (err_code == ST_OK) begin
         if (phase == PH_OPERAND) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
               frame_prod[nest] = frame_prod[nest] * 32'(ch - CH_ZERO);
               phase = PH_OPERATOR;
            end else if (ch == CH_OPEN) begin
               if (nest >= MAX_NEST) begin
                  latch_error(ST_TOO_DEEP, 8'd0);
               end else begin
                  nest++;
                  frame_sum[nest] = 32'd0;
                  frame_prod[nest] = 32'd1;
               end
            end else begin
               latch_error(ST_BAD_TOKEN, ch);
            end
         end else begin
            if (ch == CH_PLUS) begin
               frame_sum[nest] = frame_sum[nest] + frame_prod[nest];
               frame_prod[nest] = 32'd1;
               phase = PH_OPERAND;
            end else if (ch == CH_TIMES) begin
               phase = PH_OPERAND;
            end else if (ch == CH_CLOSE && nest > 0) begin
               // The closed group becomes one factor of the enclosing term.
               inner = frame_sum[nest] + frame_prod[nest];
               nest--;
               frame_prod[nest] = frame_prod[nest] * inner;
               phase = PH_OPERATOR;
            end else begin
               latch_error(ST_BAD_TOKEN, ch);
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      expr_result_type due;
      if (reset) begin
         clear_expr();
         results_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            apply_char(req_ch);
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("result with none outstanding: value %0d status %0d",
                                         rsp_value, rsp_status));
            end else begin
               due = results_due.pop_front();
               if (rsp_value !== $signed(due.value))
                  report_mismatch($sformatf("value %0d, expected %0d",
                                            rsp_value, $signed(due.value)));
               if (rsp_status !== due.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, due.status));
               if (rsp_bad_char !== due.bad_char)
                  report_mismatch($sformatf("bad_char 0x%02h, expected 0x%02h",
                                            rsp_bad_char, due.bad_char));
            end
         end
      end
      pending <= results_due.size();
   end

endmodule

[bench/infix_expression_evaluator_core_tb.sv]
// ---------------------------------------------------------------------------
// infix_expression_evaluator_core_tb
// Feeds the evaluator directed expressions covering every error status and
// the nesting limits, then random expressions, mostly well formed, some
// broken and some plain noise. The sender idles in bursts and the receiver
// stalls in changing patterns; the checker module judges every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_expression_evaluator_core_tb
   import iee_pkg::*;
();

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_ch = 8'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_bad_char;
   int                 fail_count;
   int                 pending;

   int                 burst_left = 0;
   int                 words_sent = 0;
   int                 stall_mode = 0;
   int                 stall_span = 0;
   logic [7:0]         expr_text[$];

   infix_expression_evaluator_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_ch       (req_ch),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_bad_char (rsp_bad_char)
   );

   expr_result_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_ch       (req_ch),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_bad_char (rsp_bad_char),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The receiver switches between no stalls, light, heavy and periodic stalls.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_span <= $urandom_range(20, 200);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= stall_span[3];
         end
      endcase
   end

   task automatic send_word(input logic [7:0] ch);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      req_valid <= 1'b1;
      req_ch <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i]);
      send_word(CH_END);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic add_factor(input int level, input int cap);
      if (level < cap && $urandom_range(0, 3) == 0) begin
         expr_text.push_back(CH_OPEN);
         add_sum(level + 1, cap);
         expr_text.push_back(CH_CLOSE);
      end else begin
         expr_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
   endtask

   task automatic add_sum(input int level, input int cap);
      int terms;
      int factors;
      terms = $urandom_range(1, 3);
      for (int t = 0; t < terms; t++) begin
         if (t != 0) expr_text.push_back(CH_PLUS);
         factors = $urandom_range(1, 2);
         for (int f = 0; f < factors; f++) begin
            if (f != 0) expr_text.push_back(CH_TIMES);
            add_factor(level, cap);
         end
      end
   endtask

   task automatic make_random_expr();
      int kind;
      int wraps;
      int pos;
      expr_text.delete();
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         repeat ($urandom_range(1, 8)) expr_text.push_back(8'($urandom_range(1, 255)));
      end else begin
         wraps = 0;
         if ($urandom_range(0, 7) == 0) begin
            wraps = ($urandom_range(0, 1) == 0) ? $urandom_range(1, MAX_NEST + 1)
                                                 : $urandom_range(MAX_NEST - 2, MAX_NEST + 1);
         end
         repeat (wraps) expr_text.push_back(CH_OPEN);
         add_sum(wraps, wraps + 3);
         repeat (wraps) expr_text.push_back(CH_CLOSE);
         // A few expressions get broken: cut short, one character replaced,
         // or a stray character slipped in.
         if (kind <= 3) begin
            case ($urandom_range(0, 2))
               0: begin
                  pos = $urandom_range(0, expr_text.size() - 1);
                  while (expr_text.size() > pos) void'(expr_text.pop_back());
               end
               1: begin
                  pos = $urandom_range(0, expr_text.size() - 1);
                  expr_text[pos] = 8'($urandom_range(1, 255));
               end
               default: begin
                  pos = $urandom_range(0, expr_text.size());
                  expr_text.insert(pos, 8'($urandom_range(1, 255)));
               end
            endcase
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_text("");
      send_text("7");
      send_text("1+2*3");
      send_text("(1+2)*3");
      send_text("2*(3+4)*5+6");
      send_text("((9))");
      send_text("+1");
      send_text("12");
      send_text("1)");
      send_text("1+a)(");
      send_text("1+");
      send_text("(1+2");
      send_text("()");
      send_text("(1)*");
      send_text("9*9*9*9*9*9*9*9*9*9*9*9*9*9+9*9*9*9*9*9*9*9*9*9*9");
      send_word(8'hFF);
      send_word(CH_END);

      // Deepest legal nesting, then one level too many.
      repeat (MAX_NEST) send_word(CH_OPEN);
      send_word(CH_ZERO + 8'd7);
      repeat (MAX_NEST) send_word(CH_CLOSE);
      send_word(CH_END);
      repeat (MAX_NEST + 1) send_word(CH_OPEN);
      send_word(CH_ZERO + 8'd1);
      send_word(CH_CLOSE);
      send_word(CH_END);
      drain_results();

      words_sent = 0;
      while (words_sent < 1500) begin
         make_random_expr();
         foreach (expr_text[i]) send_word(expr_text[i]);
         send_word(CH_END);
         if ($urandom_range(0, 24) == 0) drain_results();
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[infix_expression_evaluator_core.f]
rtl/core/iee_pkg.sv
rtl/core/iee_ctrl.sv
rtl/core/iee_frame_stack.sv
rtl/core/infix_expression_evaluator_core.sv
bench/expr_result_checker.sv
bench/infix_expression_evaluator_core_tb.sv
